// ----- rtl/tls_client_hello_version_classifier_macros.svh -----
// assertion helpers shared by the classifier modules
`ifndef TLS_CLIENT_HELLO_VERSION_CLASSIFIER_MACROS_SVH
`define TLS_CLIENT_HELLO_VERSION_CLASSIFIER_MACROS_SVH

// condition holds on every clock outside reset
`define TCV_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tcv invariant violated");

// consequent holds in the same cycle as the antecedent
`define TCV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcv implication violated");

// consequent holds in the cycle after the antecedent
`define TCV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcv next-cycle check violated");

`endif

// ----- rtl/tcv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcv_pkg;

   // result queue depth, must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  CONTENT_HANDSHAKE      = 8'h16;
   localparam logic [7:0]  HS_CLIENT_HELLO        = 8'h01;
   localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'd43;
   localparam logic [15:0] VER_TLS12              = 16'h0303;
   localparam logic [15:0] VER_TLS11              = 16'h0302;
   localparam logic [15:0] VER_TLS10              = 16'h0301;
   localparam logic [15:0] RANDOM_LEN             = 16'd32;

   typedef enum logic [3:0] {
      PH_CT      = 4'd0,
      PH_RECHDR  = 4'd1,
      PH_HSTYPE  = 4'd2,
      PH_HSLEN   = 4'd3,
      PH_VER     = 4'd4,
      PH_RANDOM  = 4'd5,
      PH_SIDLEN  = 4'd6,
      PH_SID     = 4'd7,
      PH_CSLEN   = 4'd8,
      PH_CS      = 4'd9,
      PH_CMLEN   = 4'd10,
      PH_CM      = 4'd11,
      PH_EXTLEN  = 4'd12,
      PH_EXTHDR  = 4'd13,
      PH_EXTBODY = 4'd14,
      PH_DONE    = 4'd15
   } phase_type;

   typedef enum logic [2:0] {
      CLS_NO_HANDSHAKE     = 3'd0,
      CLS_NOT_CLIENT_HELLO = 3'd1,
      CLS_TLS13            = 3'd2,
      CLS_TLS12            = 3'd3,
      CLS_TLS11            = 3'd4,
      CLS_TLS10            = 3'd5,
      CLS_UNKNOWN          = 3'd6,
      CLS_TRUNCATED        = 3'd7
   } class_type;

   typedef struct packed {
      class_type   hello_class;
      logic [15:0] hello_version;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/tcv_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "tls_client_hello_version_classifier_macros.svh"

module tcv_parser (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 byte_valid,
   input  wire  [7:0]          data_byte,
   input  wire                 last_byte,
   output logic                res_push,
   output tcv_pkg::result_type res_data
);
   import tcv_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] ver_ff, ver_in;
   logic        found_ff, found_in;
   class_type   early_ff, early_in;

   logic [15:0] skip_dec, rem_dec, skip_or, rem_or;
   logic        found_hdr;
   class_type   final_class;

   function automatic class_type version_class(input logic found, input logic [15:0] ver);
      class_type c;
      if (found)                 c = CLS_TLS13;
      else if (ver == VER_TLS12) c = CLS_TLS12;
      else if (ver == VER_TLS11) c = CLS_TLS11;
      else if (ver == VER_TLS10) c = CLS_TLS10;
      else                       c = CLS_UNKNOWN;
      return c;
   endfunction

   assign skip_dec  = skip_ff - 16'd1;
   assign rem_dec   = rem_ff - 16'd1;
   assign skip_or   = skip_ff | {8'h00, data_byte};
   assign rem_or    = rem_ff | {8'h00, data_byte};
   assign found_hdr = found_ff | (type_ff == EXT_SUPPORTED_VERSIONS);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      skip_in  = skip_ff;
      rem_in   = rem_ff;
      type_in  = type_ff;
      ver_in   = ver_ff;
      found_in = found_ff;
      early_in = early_ff;
      case (phase_ff)
         PH_CT: begin
            if (data_byte != CONTENT_HANDSHAKE) begin
               early_in = CLS_NO_HANDSHAKE;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_RECHDR;
               idx_in   = 2'd0;
            end
         end
         PH_RECHDR: begin
            if (idx_ff == 2'd3) begin
               phase_in = PH_HSTYPE;
               idx_in   = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         PH_HSTYPE: begin
            if (data_byte != HS_CLIENT_HELLO) begin
               early_in = CLS_NOT_CLIENT_HELLO;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_HSLEN;
               idx_in   = 2'd0;
            end
         end
         PH_HSLEN: begin
            if (idx_ff >= 2'd2) begin
               phase_in = PH_VER;
               idx_in   = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         PH_VER: begin
            if (idx_ff == 2'd0) begin
               skip_in = {8'h00, data_byte};
               idx_in  = 2'd1;
            end else begin
               ver_in   = {skip_ff[7:0], data_byte};
               skip_in  = RANDOM_LEN;
               idx_in   = 2'd0;
               phase_in = PH_RANDOM;
            end
         end
         PH_RANDOM: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) phase_in = PH_SIDLEN;
         end
         PH_SIDLEN: begin
            skip_in  = {8'h00, data_byte};
            idx_in   = 2'd0;
            phase_in = (data_byte == 8'h00) ? PH_CSLEN : PH_SID;
         end
         PH_SID: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               phase_in = PH_CSLEN;
               idx_in   = 2'd0;
            end
         end
         PH_CSLEN: begin
            if (idx_ff == 2'd0) begin
               skip_in = {data_byte, 8'h00};
               idx_in  = 2'd1;
            end else begin
               skip_in  = skip_or;
               idx_in   = 2'd0;
               phase_in = (skip_or == 16'd0) ? PH_CMLEN : PH_CS;
            end
         end
         PH_CS: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) phase_in = PH_CMLEN;
         end
         PH_CMLEN: begin
            skip_in  = {8'h00, data_byte};
            idx_in   = 2'd0;
            phase_in = (data_byte == 8'h00) ? PH_EXTLEN : PH_CM;
         end
         PH_CM: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               phase_in = PH_EXTLEN;
               idx_in   = 2'd0;
            end
         end
         PH_EXTLEN: begin
            if (idx_ff == 2'd0) begin
               rem_in = {data_byte, 8'h00};
               idx_in = 2'd1;
            end else begin
               rem_in = rem_or;
               idx_in = 2'd0;
               if (rem_or == 16'd0) begin
                  early_in = version_class(found_ff, ver_ff);
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_EXTHDR;
               end
            end
         end
         PH_EXTHDR: begin
            rem_in = rem_dec;
            case (idx_ff)
               2'd0:    type_in = {data_byte, 8'h00};
               2'd1:    type_in = type_ff | {8'h00, data_byte};
               2'd2:    skip_in = {data_byte, 8'h00};
               default: skip_in = skip_or;
            endcase
            if (idx_ff != 2'd3) begin
               // block ends inside an extension header
               if (rem_dec == 16'd0) begin
                  early_in = CLS_TRUNCATED;
                  phase_in = PH_DONE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else begin
               idx_in   = 2'd0;
               found_in = found_hdr;
               if (skip_or > rem_dec) begin
                  early_in = CLS_TRUNCATED;
                  phase_in = PH_DONE;
               end else if (skip_or == 16'd0) begin
                  if (rem_dec == 16'd0) begin
                     early_in = version_class(found_hdr, ver_ff);
                     phase_in = PH_DONE;
                  end
               end else begin
                  phase_in = PH_EXTBODY;
               end
            end
         end
         PH_EXTBODY: begin
            skip_in = skip_dec;
            rem_in  = rem_dec;
            if (skip_dec == 16'd0) begin
               if (rem_dec == 16'd0) begin
                  early_in = version_class(found_ff, ver_ff);
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_EXTHDR;
                  idx_in   = 2'd0;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // class on the final byte, from the state this byte leaves behind
   always_comb begin
      if (phase_in == PH_DONE)
         final_class = early_in;
      else if (phase_in == PH_EXTLEN && idx_in == 2'd0)
         final_class = version_class(found_in, ver_in);
      else
         final_class = CLS_TRUNCATED;
   end

   assign res_push               = byte_valid & last_byte;
   assign res_data.hello_class   = final_class;
   assign res_data.hello_version = ver_in;

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && last_byte)) begin
         phase_ff <= PH_CT;
         idx_ff   <= 2'd0;
         skip_ff  <= 16'd0;
         rem_ff   <= 16'd0;
         type_ff  <= 16'd0;
         ver_ff   <= 16'd0;
         found_ff <= 1'b0;
         early_ff <= CLS_NO_HANDSHAKE;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         skip_ff  <= skip_in;
         rem_ff   <= rem_in;
         type_ff  <= type_in;
         ver_ff   <= ver_in;
         found_ff <= found_in;
         early_ff <= early_in;
      end
   end

   `TCV_ASSERT_NEXT(a_restart_after_last, clock, reset, byte_valid && last_byte, phase_ff == PH_CT && ver_ff == 16'd0)
   `TCV_ASSERT_NEXT(a_done_holds, clock, reset, byte_valid && !last_byte && phase_ff == PH_DONE, phase_ff == PH_DONE && $stable(early_ff))
   `TCV_ASSERT_IMPL(a_body_within_block, clock, reset, phase_ff == PH_EXTBODY, skip_ff != 16'd0 && skip_ff <= rem_ff)

endmodule

`default_nettype wire

// ----- rtl/tcv_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "tls_client_hello_version_classifier_macros.svh"

module tcv_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  tcv_pkg::result_type push_data,
   output logic                full,
   input  wire                 pop,
   output logic                empty,
   output tcv_pkg::result_type head
);
   import tcv_pkg::*;

   result_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + QUEUE_CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `TCV_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `TCV_ASSERT_NEXT(a_push_fills, clock, reset, do_push && !do_pop, !empty)
   `TCV_ASSERT_NEXT(a_last_pop_empties, clock, reset, do_pop && !do_push && count_ff == QUEUE_CNT_W'(1), empty)

endmodule

`default_nettype wire

// ----- rtl/tls_client_hello_version_classifier.sv -----
// result path: a result enters the queue at the edge that takes the final byte
//   and shows on the rsp_ ports from the next cycle on
// throughput: one byte per cycle, set by the byte-wise parse state machine;
//   req_full rises only while four results wait unread in the result queue
// reset: synchronous, active high; parser returns to the content type phase
//   and the result queue empties, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module tls_client_hello_version_classifier (
   input  wire         clock,
   input  wire         reset,
   // byte input channel
   input  wire         req_push,
   output logic        req_full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   // result channel
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [2:0]  rsp_hello_class,
   output logic        rsp_forward,
   output logic [15:0] rsp_hello_version
);
   import tcv_pkg::*;

   logic       byte_accept;
   logic       res_push;
   result_type res_data;
   result_type head;

   // a byte transaction completes whenever the queue has room
   assign byte_accept = req_push & ~req_full;

   // front: byte-wise parser, classifies each buffer on its final byte
   tcv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   // back: short result queue, drains on its own pace
   tcv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (req_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_hello_class   = head.hello_class;
   assign rsp_hello_version = head.hello_version;

   // pass through to the server: anything but tls 1.3, tls 1.2 or an unknown version
   always_comb begin
      rsp_forward = head.hello_class inside {CLS_NO_HANDSHAKE, CLS_NOT_CLIENT_HELLO,
                                             CLS_TLS11, CLS_TLS10, CLS_TRUNCATED};
   end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import tcv_pkg::*;

   // expected result of one buffer
   typedef struct packed {
      class_type   cls;
      logic        fwd;
      logic [15:0] ver;
   } verdict_type;

   // one row of the opening byte table; want is used only where typed is set
   typedef struct packed {
      logic [7:0]  data;
      logic        fin;
      logic        typed;
      verdict_type want;
   } stim_row_type;

   // how a generated hello is bent before it goes out
   typedef enum {
      SHAPE_FULL,        // complete, well-formed
      SHAPE_NO_EXT,      // stops right after the compression methods
      SHAPE_CUT,         // cut off at a random byte
      SHAPE_TRAILING,    // junk after the walk has finished
      SHAPE_BAD_EXTLEN,  // extension block length off by a few bytes
      SHAPE_LONG_EXT,    // last extension claims more than is left
      SHAPE_HDR_CUT      // block ends inside an extension header
   } hello_shape_type;

   localparam verdict_type NO_VERDICT  = '{CLS_NO_HANDSHAKE, 1'b0, 16'h0000};
   localparam int          OPENING_N   = 22;
   localparam int          HOLD_CYCLES = 300;    // long receiver stall
   localparam int          QUIET_LIMIT = 5000;   // cycles without any transaction
   localparam int          TAIL_CYCLES = 8;      // result shows in the cycle after the last byte

   // opening table: short buffers whose result is plain to see
   localparam stim_row_type OPENING_ROWS [OPENING_N] = '{
      // lowest byte value, not a handshake
      '{8'h00, 1'b1, 1'b1, '{CLS_NO_HANDSHAKE, 1'b1, 16'h0000}},
      // highest byte value, not a handshake
      '{8'hFF, 1'b1, 1'b1, '{CLS_NO_HANDSHAKE, 1'b1, 16'h0000}},
      // bytes after the decision are ignored
      '{8'h17, 1'b0, 1'b0, NO_VERDICT},
      '{8'hAA, 1'b0, 1'b0, NO_VERDICT},
      '{8'h55, 1'b1, 1'b1, '{CLS_NO_HANDSHAKE, 1'b1, 16'h0000}},
      // content type alone, ends early
      '{8'h16, 1'b1, 1'b1, '{CLS_TRUNCATED, 1'b1, 16'h0000}},
      // handshake but not a client hello
      '{8'h16, 1'b0, 1'b0, NO_VERDICT},
      '{8'h03, 1'b0, 1'b0, NO_VERDICT},
      '{8'h01, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h2A, 1'b0, 1'b0, NO_VERDICT},
      '{8'h02, 1'b1, 1'b1, '{CLS_NOT_CLIENT_HELLO, 1'b1, 16'h0000}},
      // client hello cut after the first version byte, version not reached
      '{8'h16, 1'b0, 1'b0, NO_VERDICT},
      '{8'h03, 1'b0, 1'b0, NO_VERDICT},
      '{8'h03, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'h01, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h40, 1'b0, 1'b0, NO_VERDICT},
      '{8'h03, 1'b1, 1'b1, '{CLS_TRUNCATED, 1'b1, 16'h0000}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_hello_class;
   logic        rsp_forward;
   logic [15:0] rsp_hello_version;

   tls_client_hello_version_classifier u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_hello_class   (rsp_hello_class),
      .rsp_forward       (rsp_forward),
      .rsp_hello_version (rsp_hello_version)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // parser mirror: own copy of the byte-wise walk
   // ------------------------------------------------------------------
   phase_type   prs_phase;
   logic [1:0]  prs_idx;        // byte position inside a multi-byte field
   logic [15:0] prs_skip;       // bytes left to skip, or high byte being assembled
   logic [15:0] prs_ext_left;   // bytes left in the extension block
   logic [15:0] prs_ext_kind;   // extension type being read
   logic [15:0] prs_version;    // captured legacy version
   logic        prs_v13;        // supported_versions seen
   class_type   prs_early;      // class fixed before the final byte

   verdict_type expected_verdicts [$];
   int          mismatch_count  = 0;
   int          bytes_sent      = 0;
   int          quiet_cycles    = 0;

   // sender side bookkeeping
   logic        drv_has_typed = 1'b0;
   verdict_type drv_typed     = NO_VERDICT;
   logic [7:0]  msg [$];
   int          send_idle_pct = 18;
   int          pop_idle_pct  = 71;
   logic        stall_rsp     = 1'b0;

   function automatic void clear_parser();
      prs_phase    = PH_CT;
      prs_idx      = 2'd0;
      prs_skip     = 16'd0;
      prs_ext_left = 16'd0;
      prs_ext_kind = 16'd0;
      prs_version  = 16'd0;
      prs_v13      = 1'b0;
      prs_early    = CLS_NO_HANDSHAKE;
   endfunction

   function automatic class_type version_verdict();
      if (prs_v13) return CLS_TLS13;
      if (prs_version == VER_TLS12) return CLS_TLS12;
      if (prs_version == VER_TLS11) return CLS_TLS11;
      if (prs_version == VER_TLS10) return CLS_TLS10;
      return CLS_UNKNOWN;
   endfunction

   function automatic logic forwarded(class_type c);
      return (c == CLS_NO_HANDSHAKE) || (c == CLS_NOT_CLIENT_HELLO) ||
             (c == CLS_TLS11) || (c == CLS_TLS10) || (c == CLS_TRUNCATED);
   endfunction

   function automatic void settle(class_type c);
      prs_early = c;
      prs_phase = PH_DONE;
   endfunction

   function automatic void advance_parser(logic [7:0] b);
      case (prs_phase)
         PH_CT: begin
            if (b != CONTENT_HANDSHAKE) settle(CLS_NO_HANDSHAKE);
            else begin
               prs_phase = PH_RECHDR;
               prs_idx   = 2'd0;
            end
         end
         // record version and length, four bytes
         PH_RECHDR: begin
            if (prs_idx == 2'd3) begin
               prs_phase = PH_HSTYPE;
               prs_idx   = 2'd0;
            end else prs_idx = prs_idx + 2'd1;
         end
         PH_HSTYPE: begin
            if (b != HS_CLIENT_HELLO) settle(CLS_NOT_CLIENT_HELLO);
            else begin
               prs_phase = PH_HSLEN;
               prs_idx   = 2'd0;
            end
         end
         // handshake length, three bytes
         PH_HSLEN: begin
            if (prs_idx >= 2'd2) begin
               prs_phase = PH_VER;
               prs_idx   = 2'd0;
            end else prs_idx = prs_idx + 2'd1;
         end
         PH_VER: begin
            if (prs_idx == 2'd0) begin
               prs_skip = {8'h00, b};
               prs_idx  = 2'd1;
            end else begin
               prs_version = {prs_skip[7:0], b};
               prs_skip    = RANDOM_LEN;
               prs_idx     = 2'd0;
               prs_phase   = PH_RANDOM;
            end
         end
         PH_RANDOM: begin
            prs_skip = prs_skip - 16'd1;
            if (prs_skip == 16'd0) prs_phase = PH_SIDLEN;
         end
         PH_SIDLEN: begin
            prs_skip = {8'h00, b};
            prs_idx  = 2'd0;
            if (b == 8'h00) prs_phase = PH_CSLEN;
            else prs_phase = PH_SID;
         end
         PH_SID: begin
            prs_skip = prs_skip - 16'd1;
            if (prs_skip == 16'd0) begin
               prs_phase = PH_CSLEN;
               prs_idx   = 2'd0;
            end
         end
         PH_CSLEN: begin
            if (prs_idx == 2'd0) begin
               prs_skip = {b, 8'h00};
               prs_idx  = 2'd1;
            end else begin
               prs_skip = prs_skip | {8'h00, b};
               prs_idx  = 2'd0;
               if (prs_skip == 16'd0) prs_phase = PH_CMLEN;
               else prs_phase = PH_CS;
            end
         end
         PH_CS: begin
            prs_skip = prs_skip - 16'd1;
            if (prs_skip == 16'd0) prs_phase = PH_CMLEN;
         end
         PH_CMLEN: begin
            prs_skip = {8'h00, b};
            prs_idx  = 2'd0;
            if (b == 8'h00) prs_phase = PH_EXTLEN;
            else prs_phase = PH_CM;
         end
         PH_CM: begin
            prs_skip = prs_skip - 16'd1;
            if (prs_skip == 16'd0) begin
               prs_phase = PH_EXTLEN;
               prs_idx   = 2'd0;
            end
         end
         PH_EXTLEN: begin
            if (prs_idx == 2'd0) begin
               prs_ext_left = {b, 8'h00};
               prs_idx      = 2'd1;
            end else begin
               prs_ext_left = prs_ext_left | {8'h00, b};
               prs_idx      = 2'd0;
               if (prs_ext_left == 16'd0) settle(version_verdict());
               else prs_phase = PH_EXTHDR;
            end
         end
         // type and length of one extension, each byte counted against the block
         PH_EXTHDR: begin
            prs_ext_left = prs_ext_left - 16'd1;
            case (prs_idx)
               2'd0:    prs_ext_kind = {b, 8'h00};
               2'd1:    prs_ext_kind = prs_ext_kind | {8'h00, b};
               2'd2:    prs_skip     = {b, 8'h00};
               default: prs_skip     = prs_skip | {8'h00, b};
            endcase
            if (prs_idx < 2'd3) begin
               if (prs_ext_left == 16'd0) settle(CLS_TRUNCATED);
               else prs_idx = prs_idx + 2'd1;
            end else begin
               prs_idx = 2'd0;
               if (prs_ext_kind == EXT_SUPPORTED_VERSIONS) prs_v13 = 1'b1;
               if (prs_skip > prs_ext_left) settle(CLS_TRUNCATED);
               else if (prs_skip == 16'd0) begin
                  if (prs_ext_left == 16'd0) settle(version_verdict());
               end else prs_phase = PH_EXTBODY;
            end
         end
         PH_EXTBODY: begin
            prs_skip     = prs_skip - 16'd1;
            prs_ext_left = prs_ext_left - 16'd1;
            if (prs_skip == 16'd0) begin
               if (prs_ext_left == 16'd0) settle(version_verdict());
               else begin
                  prs_phase = PH_EXTHDR;
                  prs_idx   = 2'd0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // one accepted byte; a final byte closes the buffer and yields a verdict
   function automatic void track_byte(input logic [7:0] b, input logic fin,
                                      output logic produced, output verdict_type v);
      class_type c;
      advance_parser(b);
      produced = fin;
      v        = NO_VERDICT;
      if (fin) begin
         if (prs_phase == PH_DONE) c = prs_early;
         // ended right after the compression methods: empty extension block
         else if (prs_phase == PH_EXTLEN && prs_idx == 2'd0) c = version_verdict();
         else c = CLS_TRUNCATED;
         v.cls = c;
         v.fwd = forwarded(c);
         v.ver = prs_version;
         clear_parser();
      end
   endfunction

   // ------------------------------------------------------------------
   // monitor: predict on accepted bytes, compare on accepted results
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic        produced;
      verdict_type model_v;
      verdict_type want;
      if (!reset) begin
         if (req_push && !req_full) begin
            track_byte(req_data_byte, req_last_byte, produced, model_v);
            if (produced) begin
               // typed rows override the mirror, which still tracks the bytes
               expected_verdicts.push_back(drv_has_typed ? drv_typed : model_v);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result class %0d fwd %0b version %h", $time,
                        rsp_hello_class, rsp_forward, rsp_hello_version);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_hello_class !== want.cls || rsp_forward !== want.fwd ||
                   rsp_hello_version !== want.ver) begin
                  $display("%0t: expected class %0d fwd %0b version %h, got %0d %0b %h",
                           $time, want.cls, want.fwd, want.ver,
                           rsp_hello_class, rsp_forward, rsp_hello_version);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver: random pops, plus one long stall on request
   initial begin
      forever begin
         @(negedge clock);
         if (stall_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_rsp = 1'b0;
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic fin,
                            input logic typed, input verdict_type tv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      drv_has_typed = typed;
      drv_typed     = tv;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // sender goes quiet until every expected result has been popped
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (expected_verdicts.size() != 0);
   endtask

   function automatic void put_rand(int n);
      repeat (n) msg.push_back(8'($urandom_range(255)));
   endfunction

   task automatic send_buffer();
      for (int i = 0; i < msg.size(); i++)
         send_byte(msg[i], i == msg.size() - 1, 1'b0, NO_VERDICT);
   endtask

   // client hello with random content and the given sizes
   task automatic send_hello(input logic [15:0] ver, input int sid_n, input int cs_n,
                             input int cm_n, input int n_ext, input hello_shape_type shape,
                             input logic want13);
      int          body_len [4];
      logic [15:0] kind [4];
      int          ext_total;
      int          declared;
      int          delta;
      int          cut;
      logic [15:0] len_field;
      msg.delete();
      msg.push_back(CONTENT_HANDSHAKE);
      put_rand(4);
      msg.push_back(HS_CLIENT_HELLO);
      put_rand(3);
      msg.push_back(ver[15:8]);
      msg.push_back(ver[7:0]);
      put_rand(int'(RANDOM_LEN));
      msg.push_back(sid_n[7:0]);
      put_rand(sid_n);
      msg.push_back(cs_n[15:8]);
      msg.push_back(cs_n[7:0]);
      put_rand(cs_n);
      msg.push_back(cm_n[7:0]);
      put_rand(cm_n);
      if (shape == SHAPE_LONG_EXT && n_ext == 0) n_ext = 1;
      if (shape != SHAPE_NO_EXT) begin
         ext_total = 0;
         for (int i = 0; i < n_ext; i++) begin
            body_len[i] = $urandom_range(4);
            // byte-swapped and neighboring codes next to the real one
            case ($urandom_range(4))
               0:       kind[i] = 16'h2B00;
               1:       kind[i] = EXT_SUPPORTED_VERSIONS + 16'd1;
               2:       kind[i] = 16'h0000;
               3:       kind[i] = EXT_SUPPORTED_VERSIONS;
               default: kind[i] = 16'($urandom);
            endcase
            if (want13 && i == n_ext - 1) kind[i] = EXT_SUPPORTED_VERSIONS;
            ext_total += 4 + body_len[i];
         end
         declared = ext_total;
         delta    = $urandom_range(1, 3);
         if (shape == SHAPE_BAD_EXTLEN) begin
            if ($urandom_range(1) == 1) declared = ext_total + delta;
            else declared = (ext_total > delta) ? ext_total - delta : 0;
         end else if (shape == SHAPE_HDR_CUT) declared = ext_total + delta;
         msg.push_back(declared[15:8]);
         msg.push_back(declared[7:0]);
         for (int i = 0; i < n_ext; i++) begin
            len_field = 16'(body_len[i]);
            if (shape == SHAPE_LONG_EXT && i == n_ext - 1)
               len_field = len_field + 16'($urandom_range(1, 20));
            msg.push_back(kind[i][15:8]);
            msg.push_back(kind[i][7:0]);
            msg.push_back(len_field[15:8]);
            msg.push_back(len_field[7:0]);
            put_rand(body_len[i]);
         end
         // partial header that runs past the declared block
         if (shape == SHAPE_HDR_CUT) put_rand(4);
      end
      if (shape == SHAPE_CUT) begin
         cut = $urandom_range(1, msg.size() - 1);
         repeat (msg.size() - cut) void'(msg.pop_back());
      end else if (shape == SHAPE_TRAILING) put_rand($urandom_range(1, 5));
      send_buffer();
   endtask

   // short junk buffer, sometimes past the content type check
   task automatic send_noise();
      msg.delete();
      if ($urandom_range(1) == 1) begin
         msg.push_back(CONTENT_HANDSHAKE);
         put_rand(5);
         put_rand($urandom_range(3));
      end else put_rand($urandom_range(1, 6));
      send_buffer();
   endtask

   task automatic send_random_buffer();
      logic [15:0]     ver;
      int              sid_n;
      int              cs_n;
      int              pick;
      hello_shape_type shape;
      if ($urandom_range(99) < 30) send_noise();
      else begin
         case ($urandom_range(6))
            0:       ver = VER_TLS12;
            1:       ver = VER_TLS11;
            2:       ver = VER_TLS10;
            3:       ver = 16'h0300;
            4:       ver = 16'h0304;
            5:       ver = 16'hFFFF;
            default: ver = 16'($urandom);
         endcase
         // mostly small fields, now and then a large one
         if ($urandom_range(9) == 0) sid_n = ($urandom_range(1) == 1) ? 32 : 255;
         else sid_n = $urandom_range(4);
         if ($urandom_range(11) == 0) cs_n = 256 + $urandom_range(40);
         else cs_n = $urandom_range(6);
         pick = $urandom_range(99);
         if (pick < 35) shape = SHAPE_FULL;
         else if (pick < 45) shape = SHAPE_NO_EXT;
         else if (pick < 60) shape = SHAPE_CUT;
         else if (pick < 70) shape = SHAPE_TRAILING;
         else if (pick < 80) shape = SHAPE_BAD_EXTLEN;
         else if (pick < 90) shape = SHAPE_LONG_EXT;
         else shape = SHAPE_HDR_CUT;
         send_hello(ver, sid_n, cs_n, $urandom_range(3), $urandom_range(3), shape,
                    $urandom_range(2) == 0);
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int b0;
      clear_parser();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // opening table
      for (int i = 0; i < OPENING_N; i++)
         send_byte(OPENING_ROWS[i].data, OPENING_ROWS[i].fin, OPENING_ROWS[i].typed,
                   OPENING_ROWS[i].want);

      // hand-picked hellos: zero lengths and empty extension block
      send_hello(VER_TLS12, 0, 0, 0, 0, SHAPE_FULL, 1'b0);
      // missing extensions
      send_hello(VER_TLS12, 2, 4, 1, 0, SHAPE_NO_EXT, 1'b0);
      // supported_versions wins over the legacy version
      send_hello(VER_TLS11, 1, 2, 1, 2, SHAPE_FULL, 1'b1);
      send_hello(VER_TLS10, 0, 2, 1, 2, SHAPE_FULL, 1'b0);
      send_hello(16'hFFFF, 3, 2, 1, 1, SHAPE_FULL, 1'b0);
      send_hello(16'h0000, 0, 2, 1, 1, SHAPE_FULL, 1'b0);
      // malformed extension block, both ways
      send_hello(VER_TLS12, 0, 2, 1, 2, SHAPE_LONG_EXT, 1'b0);
      send_hello(VER_TLS12, 0, 2, 1, 1, SHAPE_HDR_CUT, 1'b0);
      // junk after a finished walk, and an early end
      send_hello(VER_TLS12, 0, 2, 1, 1, SHAPE_TRAILING, 1'b1);
      send_hello(VER_TLS12, 1, 2, 1, 1, SHAPE_CUT, 1'b0);

      // receiver stalls while one-byte buffers pile up and fill the queue
      stall_rsp = 1'b1;
      repeat (10) send_byte(8'($urandom_range(8'h15)), 1'b1, 1'b0, NO_VERDICT);
      drain_results();

      // random part in three idling profiles, last one without idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 71 : 0;
         pop_idle_pct  = (ph == 0) ? 71 : (ph == 1) ? 18 : 0;
         b0 = bytes_sent;
         while (bytes_sent - b0 < 50) send_random_buffer();
         drain_results();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcv_pkg.sv
rtl/tcv_parser.sv
rtl/tcv_queue.sv
rtl/tls_client_hello_version_classifier.sv
dv/testbench.sv
